[rtl/core/sfbb_pkg.sv]
// Shared types and constants for the square fill blitter.
// No dependencies; imported by every module of the block but sfbb_ram.
package sfbb_pkg;

   // Defaults and fixed field widths
   localparam int SFBB_CANVAS_SIDE = 128;
   localparam int SFBB_QUEUE_DEPTH = 4;
   localparam int POS_W = 7;
   localparam int SIDE_W = 8;
   localparam int CHAN_W = 8;
   localparam int PIX_W = 3 * CHAN_W;
   localparam int OUT_BOX_W = 8;
   // A square end before clamping is at most 127 + 255 = 382, so nine bits hold it
   localparam int CRD_W = 9;

   localparam logic [PIX_W-1:0] WHITE_PIXEL = 24'hFFFFFF;

   localparam logic KIND_FILL = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_PAINT  = 2'd1,
      OP_READ   = 2'd2
   } sfbb_op_type;

   // One classified request, as it waits between front and back
   typedef struct packed {
      sfbb_op_type            op;
      logic                   clipped;
      logic [POS_W-1:0]       col0;
      logic [POS_W-1:0]       row0;
      logic [CRD_W-1:0]       col_end;
      logic [CRD_W-1:0]       row_end;
      logic [PIX_W-1:0]       colour;
   } sfbb_cmd_type;

endpackage

[rtl/core/square_fill_with_bounding_box.sv]
// Each request goes from the queue head through setup, then paint (a fill writes the square
// clipped to the canvas, one pixel per cycle) or read, then emit into the result register;
// off-canvas requests and zero-side fills go from setup straight to emit. The back end takes
// one request at a time; the paint loop writes through the single canvas RAM write port.
// Reset (synchronous, active high) starts a clearing pass that paints the canvas white;
// full stays high until it ends.
module square_fill_with_bounding_box
   import sfbb_pkg::*;
#(
   parameter int CANVAS_SIDE = SFBB_CANVAS_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  push,
   output logic                  full,
   input  logic                  req_kind,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [SIDE_W-1:0]     req_side,
   input  logic [CHAN_W-1:0]     req_fill_red,
   input  logic [CHAN_W-1:0]     req_fill_green,
   input  logic [CHAN_W-1:0]     req_fill_blue,
   // result side
   output logic                  empty,
   input  logic                  pop,
   output logic [CHAN_W-1:0]     rsp_pixel_red,
   output logic [CHAN_W-1:0]     rsp_pixel_green,
   output logic [CHAN_W-1:0]     rsp_pixel_blue,
   output logic [OUT_BOX_W-1:0]  rsp_box_min_x,
   output logic [OUT_BOX_W-1:0]  rsp_box_min_y,
   output logic [OUT_BOX_W-1:0]  rsp_box_max_x,
   output logic [OUT_BOX_W-1:0]  rsp_box_max_y,
   output logic                  rsp_clipped
);

   // Classified request heading into the queue, and the one at its head
   sfbb_cmd_type front_cmd;
   sfbb_cmd_type head_cmd;
   logic         queue_push;
   logic         queue_full;
   logic         queue_pop;
   logic         queue_empty;
   logic         clearing;

   // Front: clip the square, decide paint, read or plain report
   sfbb_front #(
      .CANVAS_SIDE (CANVAS_SIDE)
   ) u_front (
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_side       (req_side),
      .req_fill_red   (req_fill_red),
      .req_fill_green (req_fill_green),
      .req_fill_blue  (req_fill_blue),
      .queue_full     (queue_full),
      .clearing       (clearing),
      .queue_push     (queue_push),
      .cmd            (front_cmd)
   );

   // Queue: hold requests while the back end paints
   sfbb_queue #(
      .DEPTH (SFBB_QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (queue_push),
      .wr_cmd  (front_cmd),
      .q_full  (queue_full),
      .rd_en   (queue_pop),
      .rd_cmd  (head_cmd),
      .q_empty (queue_empty)
   );

   // Back: clear the canvas, then carry out requests in order and drive results
   sfbb_back #(
      .CANVAS_SIDE (CANVAS_SIDE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (queue_empty),
      .q_cmd           (head_cmd),
      .q_pop           (queue_pop),
      .clearing        (clearing),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_red   (rsp_pixel_red),
      .rsp_pixel_green (rsp_pixel_green),
      .rsp_pixel_blue  (rsp_pixel_blue),
      .rsp_box_min_x   (rsp_box_min_x),
      .rsp_box_min_y   (rsp_box_min_y),
      .rsp_box_max_x   (rsp_box_max_x),
      .rsp_box_max_y   (rsp_box_max_y),
      .rsp_clipped     (rsp_clipped)
   );

endmodule

[rtl/core/sfbb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sfbb_front.sv]
// Front end: accepts requests, clips the square against the canvas and classifies it.
// Depends on sfbb_pkg.
module sfbb_front
   import sfbb_pkg::*;
#(
   parameter int CANVAS_SIDE = SFBB_CANVAS_SIDE
) (
   input  logic               push,
   output logic               full,
   input  logic               req_kind,
   input  logic [POS_W-1:0]   req_pos_x,
   input  logic [POS_W-1:0]   req_pos_y,
   input  logic [SIDE_W-1:0]  req_side,
   input  logic [CHAN_W-1:0]  req_fill_red,
   input  logic [CHAN_W-1:0]  req_fill_green,
   input  logic [CHAN_W-1:0]  req_fill_blue,
   input  logic               queue_full,
   input  logic               clearing,
   output logic               queue_push,
   output sfbb_cmd_type       cmd
);

   localparam int SIDE_BITS = $clog2(CANVAS_SIDE + 1);
   localparam int CMP_W = (SIDE_BITS > CRD_W) ? SIDE_BITS : CRD_W;
   localparam logic [CMP_W-1:0] SIDE_C = CMP_W'(CANVAS_SIDE);

   logic [CMP_W-1:0] end_x;
   logic [CMP_W-1:0] end_y;
   logic             clip_x;
   logic             clip_y;
   logic             on_canvas;
   logic             has_side;

   assign full       = queue_full | clearing;
   assign queue_push = push & ~full;

   always_comb begin
      end_x     = CMP_W'(req_pos_x) + CMP_W'(req_side);
      end_y     = CMP_W'(req_pos_y) + CMP_W'(req_side);
      clip_x    = end_x > SIDE_C;
      clip_y    = end_y > SIDE_C;
      on_canvas = (CMP_W'(req_pos_x) < SIDE_C) && (CMP_W'(req_pos_y) < SIDE_C);
      has_side  = req_side != '0;

      cmd.col0    = req_pos_x;
      cmd.row0    = req_pos_y;
      // Clamp the far edge to the canvas; either value fits the coordinate width
      cmd.col_end = clip_x ? SIDE_C[CRD_W-1:0] : end_x[CRD_W-1:0];
      cmd.row_end = clip_y ? SIDE_C[CRD_W-1:0] : end_y[CRD_W-1:0];
      cmd.colour  = {req_fill_red, req_fill_green, req_fill_blue};
      cmd.clipped = (req_kind == KIND_FILL) && has_side && (clip_x || clip_y);

      if (req_kind == KIND_READ) begin
         cmd.op = on_canvas ? OP_READ : OP_REPORT;
      end else begin
         cmd.op = (has_side && on_canvas) ? OP_PAINT : OP_REPORT;
      end
   end

endmodule

[rtl/core/sfbb_queue.sv]
// Short command queue between front and back end.
// Depends on sfbb_pkg.
module sfbb_queue
   import sfbb_pkg::*;
#(
   parameter int DEPTH = SFBB_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  sfbb_cmd_type wr_cmd,
   output logic         q_full,
   input  logic         rd_en,
   output sfbb_cmd_type rd_cmd,
   output logic         q_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfbb_cmd_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign q_full  = count_ff == CNT_W'(DEPTH);
   assign q_empty = count_ff == '0;
   assign rd_cmd  = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en & ~q_full;
   assign do_rd   = rd_en & ~q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

[rtl/core/sfbb_back.sv]
// Back end: clears the canvas after reset, paints squares a pixel per cycle,
// reads pixels, tracks the bounding box and holds the result register.
// Depends on sfbb_pkg and sfbb_ram.
module sfbb_back
   import sfbb_pkg::*;
#(
   parameter int CANVAS_SIDE = SFBB_CANVAS_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  sfbb_cmd_type          q_cmd,
   output logic                  q_pop,
   output logic                  clearing,
   output logic                  empty,
   input  logic                  pop,
   output logic [CHAN_W-1:0]     rsp_pixel_red,
   output logic [CHAN_W-1:0]     rsp_pixel_green,
   output logic [CHAN_W-1:0]     rsp_pixel_blue,
   output logic [OUT_BOX_W-1:0]  rsp_box_min_x,
   output logic [OUT_BOX_W-1:0]  rsp_box_min_y,
   output logic [OUT_BOX_W-1:0]  rsp_box_max_x,
   output logic [OUT_BOX_W-1:0]  rsp_box_max_y,
   output logic                  rsp_clipped
);

   localparam int DEPTH = CANVAS_SIDE * CANVAS_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int BOX_W = $clog2(CANVAS_SIDE + 1);
   localparam int CMP_W = (BOX_W > CRD_W) ? BOX_W : CRD_W;
   localparam int PROD_W = (POS_W + BOX_W + 1 > ADDR_W) ? POS_W + BOX_W + 1 : ADDR_W;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SETUP = 6'b000100,
      S_PAINT = 6'b001000,
      S_READ  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   sfbb_cmd_type         cmd_ff, cmd_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [ADDR_W-1:0]    row_base_ff, row_base_in;
   logic [CRD_W-1:0]     col_ff, col_in;
   logic [CRD_W-1:0]     row_ff, row_in;
   logic [BOX_W-1:0]     min_col_ff, min_col_in;
   logic [BOX_W-1:0]     min_row_ff, min_row_in;
   logic [BOX_W-1:0]     max_col_ff, max_col_in;
   logic [BOX_W-1:0]     max_row_ff, max_row_in;
   logic                 out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]     out_pixel_ff, out_pixel_in;
   logic                 out_clipped_ff, out_clipped_in;
   logic [OUT_BOX_W-1:0] out_min_x_ff, out_min_x_in;
   logic [OUT_BOX_W-1:0] out_min_y_ff, out_min_y_in;
   logic [OUT_BOX_W-1:0] out_max_x_ff, out_max_x_in;
   logic [OUT_BOX_W-1:0] out_max_y_ff, out_max_y_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [PIX_W-1:0]     wr_data;
   logic                 rd_en;
   logic [PIX_W-1:0]     rd_data;
   logic                 out_free;
   logic [PROD_W-1:0]    row_prod;
   logic [PROD_W:0]      start_sum;
   logic [ADDR_W+1:0]    next_row_sum;
   logic [CMP_W-1:0]     col0_x, row0_x, cend_x, rend_x;
   logic [BOX_W+OUT_BOX_W-1:0] wide_min_col, wide_min_row, wide_max_col, wide_max_row;

   sfbb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign clearing = state_ff == S_CLEAR;
   assign out_free = ~out_valid_ff | pop;

   // Box fields leave masked to eight bits
   assign wide_min_col = {{OUT_BOX_W{1'b0}}, min_col_ff};
   assign wide_min_row = {{OUT_BOX_W{1'b0}}, min_row_ff};
   assign wide_max_col = {{OUT_BOX_W{1'b0}}, max_col_ff};
   assign wide_max_row = {{OUT_BOX_W{1'b0}}, max_row_ff};

   always_comb begin
      row_prod     = PROD_W'(cmd_ff.row0) * PROD_W'(CANVAS_SIDE);
      start_sum    = (PROD_W + 1)'(row_prod) + (PROD_W + 1)'(cmd_ff.col0);
      next_row_sum = (ADDR_W + 2)'(row_base_ff) + (ADDR_W + 2)'(CANVAS_SIDE)
                     + (ADDR_W + 2)'(cmd_ff.col0);
      col0_x       = CMP_W'(cmd_ff.col0);
      row0_x       = CMP_W'(cmd_ff.row0);
      cend_x       = CMP_W'(cmd_ff.col_end);
      rend_x       = CMP_W'(cmd_ff.row_end);

      state_in       = state_ff;
      cmd_in         = cmd_ff;
      clr_addr_in    = clr_addr_ff;
      addr_in        = addr_ff;
      row_base_in    = row_base_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      min_col_in     = min_col_ff;
      min_row_in     = min_row_ff;
      max_col_in     = max_col_ff;
      max_row_in     = max_row_ff;
      out_valid_in   = out_valid_ff & ~pop;
      out_pixel_in   = out_pixel_ff;
      out_clipped_in = out_clipped_ff;
      out_min_x_in   = out_min_x_ff;
      out_min_y_in   = out_min_y_ff;
      out_max_x_in   = out_max_x_ff;
      out_max_y_in   = out_max_y_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = addr_ff;
      wr_data        = cmd_ff.colour;
      rd_en          = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = WHITE_PIXEL;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            addr_in     = start_sum[ADDR_W-1:0];
            row_base_in = row_prod[ADDR_W-1:0];
            col_in      = CRD_W'(cmd_ff.col0);
            row_in      = CRD_W'(cmd_ff.row0);
            case (cmd_ff.op)
               OP_PAINT: begin
                  if (col0_x < CMP_W'(min_col_ff)) min_col_in = col0_x[BOX_W-1:0];
                  if (row0_x < CMP_W'(min_row_ff)) min_row_in = row0_x[BOX_W-1:0];
                  if (cend_x > CMP_W'(max_col_ff)) max_col_in = cend_x[BOX_W-1:0];
                  if (rend_x > CMP_W'(max_row_ff)) max_row_in = rend_x[BOX_W-1:0];
                  state_in = S_PAINT;
               end
               OP_READ:   state_in = S_READ;
               OP_REPORT: state_in = S_EMIT;
               default:   state_in = S_EMIT;
            endcase
         end
         S_PAINT: begin
            wr_en = 1'b1;
            if (col_ff + 1'b1 == cmd_ff.col_end) begin
               if (row_ff + 1'b1 == cmd_ff.row_end) begin
                  state_in = S_EMIT;
               end else begin
                  row_in      = row_ff + 1'b1;
                  col_in      = CRD_W'(cmd_ff.col0);
                  row_base_in = row_base_ff + ADDR_W'(CANVAS_SIDE);
                  addr_in     = next_row_sum[ADDR_W-1:0];
               end
            end else begin
               col_in  = col_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_pixel_in   = (cmd_ff.op == OP_READ) ? rd_data : '0;
               out_clipped_in = cmd_ff.clipped;
               out_min_x_in   = wide_min_col[OUT_BOX_W-1:0];
               out_min_y_in   = wide_min_row[OUT_BOX_W-1:0];
               out_max_x_in   = wide_max_col[OUT_BOX_W-1:0];
               out_max_y_in   = wide_max_row[OUT_BOX_W-1:0];
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         min_col_ff   <= BOX_W'(CANVAS_SIDE);
         min_row_ff   <= BOX_W'(CANVAS_SIDE);
         max_col_ff   <= '0;
         max_row_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      addr_ff        <= addr_in;
      row_base_ff    <= row_base_in;
      col_ff         <= col_in;
      row_ff         <= row_in;
      out_pixel_ff   <= out_pixel_in;
      out_clipped_ff <= out_clipped_in;
      out_min_x_ff   <= out_min_x_in;
      out_min_y_ff   <= out_min_y_in;
      out_max_x_ff   <= out_max_x_in;
      out_max_y_ff   <= out_max_y_in;
   end

   assign empty           = ~out_valid_ff;
   assign rsp_pixel_red   = out_pixel_ff[PIX_W-1 -: CHAN_W];
   assign rsp_pixel_green = out_pixel_ff[CHAN_W +: CHAN_W];
   assign rsp_pixel_blue  = out_pixel_ff[CHAN_W-1:0];
   assign rsp_box_min_x   = out_min_x_ff;
   assign rsp_box_min_y   = out_min_y_ff;
   assign rsp_box_max_x   = out_max_x_ff;
   assign rsp_box_max_y   = out_max_y_ff;
   assign rsp_clipped     = out_clipped_ff;

   // Canvas is written only by the clearing pass or the paint loop
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_PAINT))
      else $error("canvas write outside clear or paint");

   // Paint address stays on the canvas
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAINT) |-> (addr_ff <= ADDR_W'(DEPTH - 1)))
      else $error("paint address beyond canvas");

   // After a paint the box is non-empty in both axes
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && cmd_ff.op == OP_PAINT) |->
         (min_col_ff < max_col_ff && min_row_ff < max_row_ff))
      else $error("bounding box inverted after paint");

   // A new result appears only out of the emit step
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff && !pop)) |-> $past(state_ff == S_EMIT))
      else $error("result register loaded outside emit");

   // No request leaves the queue while the canvas is being cleared
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("queue popped during clearing pass");

endmodule
